// ----- rtl/core/ssrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrt_pkg
// shared types and helpers of the save slot recency table
// ----------------------------------------------------------------------------
package ssrt_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MAX_SLOTS = 64;
    localparam int IW        = 6;        // slot index / rank width inside a word
    localparam logic [7:0] FREE_MARK   = 8'hFF;
    localparam logic [6:0] SUBJECT_MAX = 7'd99;

    typedef enum logic [2:0] {
        CMD_SAVE    = 3'd0,
        CMD_CLEAR   = 3'd1,
        CMD_LATEST  = 3'd2,
        CMD_FREE    = 3'd3,
        CMD_NEXT    = 3'd4,
        CMD_LIST    = 3'd5,
        CMD_INFO    = 3'd6,
        CMD_UNKNOWN = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        K_NONE,
        K_READ,
        K_SAVE,
        K_CLEAR,
        K_LATEST,
        K_FREE,
        K_SUBJ,
        K_LIST
    } t_kind;

    // word that travels down the row of slot cells
    typedef struct packed {
        t_kind           kind;
        logic            incl;
        logic [IW-1:0]   tgt;
        logic [6:0]      key_subj;
        logic [IW-1:0]   key_rank;
        logic            prev_occ;
        logic [7:0]      chamber;
        logic            found;
        logic [IW-1:0]   res_idx;
        logic [7:0]      res_ch;
        logic [6:0]      res_subj;
        logic [IW-1:0]   res_rank;
    } t_word;

    localparam t_word W_NONE = '{kind: K_NONE, default: '0};

    function automatic logic [6:0] f_subj_inc(input logic [6:0] v);
        return (v >= SUBJECT_MAX) ? 7'd0 : v + 7'd1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ssrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrt_cell
// one save slot: holds its entry, applies passing updates, answers searches
// ----------------------------------------------------------------------------
module ssrt_cell #(
    parameter int SLOTS = ssrt_pkg::SLOTS_DEF,
    parameter int IDX   = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [2:0]     i_auto,
    input  ssrt_pkg::t_word     i_word,
    output ssrt_pkg::t_word     o_word
);
    import ssrt_pkg::*;

    localparam int RW = $clog2(SLOTS);

    logic [7:0]    r_chamber;
    logic [6:0]    r_subj;
    logic [RW-1:0] r_rank;
    t_word         r_word;
    t_word         n_word;

    logic occ, me, me_auto, excl;
    logic [RW-1:0] key_rank;

    assign occ      = (r_chamber != FREE_MARK);
    assign me       = (i_word.tgt == IW'(IDX));
    assign me_auto  = (IW'(i_auto) == IW'(IDX));
    assign excl     = me_auto && !i_word.incl;
    assign key_rank = RW'(i_word.key_rank);

    always_comb begin
        n_word = i_word;
        case (i_word.kind)
            K_READ: begin
                if (me) begin
                    n_word.found    = 1'b1;
                    n_word.res_idx  = IW'(IDX);
                    n_word.res_ch   = r_chamber;
                    n_word.res_subj = r_subj;
                    n_word.res_rank = IW'(r_rank);
                end
            end
            K_LATEST: begin
                if (occ && !excl && r_subj == i_word.key_subj &&
                    (!i_word.found || IW'(r_rank) < i_word.res_rank)) begin
                    n_word.found    = 1'b1;
                    n_word.res_idx  = IW'(IDX);
                    n_word.res_ch   = r_chamber;
                    n_word.res_subj = r_subj;
                    n_word.res_rank = IW'(r_rank);
                end
            end
            K_FREE: begin
                if (!i_word.found && !me_auto && !occ) begin
                    n_word.found   = 1'b1;
                    n_word.res_idx = IW'(IDX);
                    n_word.res_ch  = FREE_MARK;
                end
            end
            K_SUBJ: begin
                if (occ && r_subj == i_word.key_subj) begin
                    n_word.found = 1'b1;
                end
            end
            K_LIST: begin
                if (occ && !excl && r_rank == key_rank) begin
                    n_word.found    = 1'b1;
                    n_word.res_idx  = IW'(IDX);
                    n_word.res_ch   = r_chamber;
                    n_word.res_subj = r_subj;
                    n_word.res_rank = IW'(r_rank);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chamber   <= FREE_MARK;
            r_word.kind <= K_NONE;
        end else begin
            r_word <= n_word;
            if (i_word.kind == K_SAVE) begin
                if (me) begin
                    r_chamber <= i_word.chamber;
                    r_subj    <= i_word.key_subj;
                    r_rank    <= '0;
                end else if (occ && (!i_word.prev_occ || r_rank < key_rank)) begin
                    r_rank <= r_rank + RW'(1);
                end
            end else if (i_word.kind == K_CLEAR) begin
                if (me) begin
                    r_chamber <= FREE_MARK;
                end else if (occ && i_word.prev_occ && r_rank > key_rank) begin
                    r_rank <= r_rank - RW'(1);
                end
            end
        end
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

// ----- rtl/core/save_slot_recency_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// save_slot_recency_table_unit
// recency ordered table of save slots built as a row of slot cells
// ----------------------------------------------------------------------------
// a request word is taken at a clock edge with start high and busy low.
// results leave on o_valid, one cycle each, o_last marks the final one;
// the receiver cannot stall, so results are never held back.
// each request travels as one or more words down a row of SLOTS cells,
// one cell per cycle, apart from the last case below:
//   save, clear, slot info: a read pass first; for save and clear
//     the update pass then trails behind and overlaps the next request
//   latest of subject, first free: one word
//   list: SLOTS words, one per rank, results follow the found entries
//     and the last one comes once every word is back
//   next subject: SLOTS + 1 candidate words
//   out of range slot and unknown command: no words, result in the next cycle
// o_next_subject always shows the subject counter.
// reset frees every slot, zeroes the counter and the autosave index.
// the autosave index register sits at addresses 0 to 3 of the apb port.
// ----------------------------------------------------------------------------
module save_slot_recency_table_unit #(
    parameter int SLOTS = ssrt_pkg::SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [2:0]  i_slot,
    input  wire logic [7:0]  i_chamber,
    input  wire logic [6:0]  i_subject,
    input  wire logic        i_include_auto,
    output logic             o_valid,
    output logic             o_found,
    output logic [2:0]       o_result_slot,
    output logic [7:0]       o_result_chamber,
    output logic [7:0]       o_result_subject,
    output logic [6:0]       o_next_subject,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ssrt_pkg::*;

    localparam int CW = $clog2(SLOTS + 2);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_ONE, S_SUBJ, S_LIST, S_LEND} t_state;

    typedef struct packed {
        logic       found;
        logic [2:0] slot;
        logic [7:0] ch;
        logic [7:0] subj;
    } t_res;

    t_state        r_state;
    t_word         r_head;
    t_cmd          r_cmd;
    logic [2:0]    r_slot;
    logic [7:0]    r_chamber;
    logic [6:0]    r_subject;
    logic          r_incl;
    logic [CW-1:0] r_icnt;
    logic [CW-1:0] r_rcnt;
    logic [6:0]    r_ckey;
    logic [6:0]    r_cnt;
    logic          r_done;
    t_word         r_held;
    logic          r_hvalid;
    logic [2:0]    r_auto;
    logic          r_valid;
    logic          r_last;
    t_res          r_res;

    t_word chain [SLOTS+1];
    t_word tail;

    assign chain[0] = r_head;
    assign tail     = chain[SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ssrt_cell #(.SLOTS(SLOTS), .IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_auto (r_auto),
            .i_word (chain[g]),
            .o_word (chain[g+1])
        );
    end

    function automatic t_res f_res(input logic f, input logic [2:0] s,
                                   input logic [7:0] c, input logic [7:0] u);
        t_res r;
        r.found = f;
        r.slot  = s;
        r.ch    = c;
        r.subj  = u;
        return r;
    endfunction

    function automatic t_res f_from_word(input t_word w);
        t_res r;
        r.found = 1'b1;
        r.slot  = 3'(w.res_idx);
        r.ch    = w.res_ch;
        r.subj  = (w.res_ch == FREE_MARK) ? FREE_MARK : {1'b0, w.res_subj};
        return r;
    endfunction

    t_res none_res;
    assign none_res = f_res(1'b0, 3'd0, FREE_MARK, FREE_MARK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head.kind <= K_NONE;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_hvalid    <= 1'b0;
            r_auto      <= '0;
            r_valid     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_head  <= W_NONE;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_auto <= pwdata[2:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd     <= t_cmd'(i_cmd);
                        r_slot    <= i_slot;
                        r_chamber <= i_chamber;
                        r_subject <= i_subject;
                        r_incl    <= i_include_auto;
                        r_icnt    <= CW'(1);
                        r_rcnt    <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_SAVE, CMD_CLEAR, CMD_INFO: begin
                                if (32'(i_slot) < SLOTS) begin
                                    r_head.kind <= K_READ;
                                    r_head.tgt  <= IW'(i_slot);
                                    r_state     <= S_READ;
                                end else begin
                                    r_res   <= f_res(1'b0, i_slot, FREE_MARK, FREE_MARK);
                                    r_valid <= 1'b1;
                                    r_last  <= 1'b1;
                                end
                            end
                            CMD_LATEST: begin
                                r_head.kind     <= K_LATEST;
                                r_head.key_subj <= i_subject;
                                r_head.incl     <= i_include_auto;
                                r_state         <= S_ONE;
                            end
                            CMD_FREE: begin
                                r_head.kind <= K_FREE;
                                r_state     <= S_ONE;
                            end
                            CMD_NEXT: begin
                                r_head.kind     <= K_SUBJ;
                                r_head.key_subj <= r_cnt;
                                r_ckey          <= f_subj_inc(r_cnt);
                                r_done          <= 1'b0;
                                r_state         <= S_SUBJ;
                            end
                            CMD_LIST: begin
                                r_head.kind     <= K_LIST;
                                r_head.key_rank <= '0;
                                r_head.incl     <= i_include_auto;
                                r_hvalid        <= 1'b0;
                                r_state         <= S_LIST;
                            end
                            default: begin
                                r_res   <= none_res;
                                r_valid <= 1'b1;
                                r_last  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (tail.kind == K_READ) begin
                        r_valid <= 1'b1;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_INFO) begin
                            r_res <= f_from_word(tail);
                        end else begin
                            // the update word leads any later request down the row
                            r_head.tgt      <= IW'(r_slot);
                            r_head.key_rank <= tail.res_rank;
                            r_head.prev_occ <= (tail.res_ch != FREE_MARK);
                            r_head.chamber  <= r_chamber;
                            r_head.key_subj <= r_subject;
                            if (r_cmd == CMD_SAVE && r_chamber != FREE_MARK) begin
                                r_head.kind <= K_SAVE;
                                r_res <= f_res(1'b1, r_slot, r_chamber, {1'b0, r_subject});
                            end else begin
                                r_head.kind <= K_CLEAR;
                                r_res <= f_res(1'b1, r_slot, FREE_MARK, FREE_MARK);
                            end
                        end
                    end
                end
                S_ONE: begin
                    if (tail.kind == K_LATEST || tail.kind == K_FREE) begin
                        r_res   <= tail.found ? f_from_word(tail) : none_res;
                        r_valid <= 1'b1;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SUBJ: begin
                    if (32'(r_icnt) < SLOTS + 1) begin
                        r_head.kind     <= K_SUBJ;
                        r_head.key_subj <= r_ckey;
                        r_ckey          <= f_subj_inc(r_ckey);
                        r_icnt          <= r_icnt + CW'(1);
                    end
                    if (tail.kind == K_SUBJ) begin
                        // candidates come back in order, stop at the first unused one
                        if (!r_done) begin
                            if (tail.found) begin
                                r_cnt <= f_subj_inc(r_cnt);
                            end else begin
                                r_done <= 1'b1;
                            end
                        end
                        r_rcnt <= r_rcnt + CW'(1);
                        if (32'(r_rcnt) == SLOTS) begin
                            r_res   <= none_res;
                            r_valid <= 1'b1;
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LIST: begin
                    if (32'(r_icnt) < SLOTS) begin
                        r_head.kind     <= K_LIST;
                        r_head.key_rank <= IW'(r_icnt);
                        r_head.incl     <= r_incl;
                        r_icnt          <= r_icnt + CW'(1);
                    end
                    if (tail.kind == K_LIST) begin
                        // hold one entry back so the final one can carry last
                        if (tail.found) begin
                            if (r_hvalid) begin
                                r_res   <= f_from_word(r_held);
                                r_valid <= 1'b1;
                                r_last  <= 1'b0;
                            end
                            r_held   <= tail;
                            r_hvalid <= 1'b1;
                        end
                        r_rcnt <= r_rcnt + CW'(1);
                        if (32'(r_rcnt) == SLOTS - 1) begin
                            r_state <= S_LEND;
                        end
                    end
                end
                S_LEND: begin
                    r_res   <= r_hvalid ? f_from_word(r_held) : none_res;
                    r_valid <= 1'b1;
                    r_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_found          = r_res.found;
    assign o_result_slot    = r_res.slot;
    assign o_result_chamber = r_res.ch;
    assign o_result_subject = r_res.subj;
    assign o_next_subject   = r_cnt;
    assign o_last           = r_last;
    assign pready           = 1'b1;
    assign prdata           = paddr[2] ? 32'd0 : {29'd0, r_auto};

endmodule
`default_nettype wire

// ----- rtl/core/ssrt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrt_checker
// port level checks of the save slot recency table
// ----------------------------------------------------------------------------
module ssrt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] i_cmd,
    input wire logic       o_valid,
    input wire logic       o_found,
    input wire logic [7:0] o_result_chamber,
    input wire logic [7:0] o_result_subject,
    input wire logic [6:0] o_next_subject,
    input wire logic       o_last
);
    import ssrt_pkg::*;

    // a word without an answer reports free fields
    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_result_chamber == FREE_MARK &&
                                o_result_subject == FREE_MARK)
        else $error("no-answer word with stored fields");

    a_unknown_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_UNKNOWN |=> o_valid && o_last && !o_found)
        else $error("unknown command not answered in one cycle");

    // more words of the same list still to come
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("list ended without a last word");

    a_subject_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_next_subject <= SUBJECT_MAX)
        else $error("subject counter out of range");

endmodule

bind save_slot_recency_table_unit ssrt_checker u_ssrt_checker (.*);
`default_nettype wire

// ----- test/tb_save_slot_recency_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_save_slot_recency_table_unit
// self-checking bench for the save slot recency table
// ----------------------------------------------------------------------------
// requests go in on the start/busy handshake; a table mirror in the bench
// works out every result word, and each o_valid word is matched against the
// oldest pending one. directed tests cover empty and full tables, the
// autosave slot, save with the free marker and subject wrap; then random
// traffic runs under several sender idle levels and autosave settings.
// ----------------------------------------------------------------------------
module tb_save_slot_recency_table_unit;
    import ssrt_pkg::*;

    localparam int NSLOT = 8;

    typedef struct packed {
        logic       found;
        logic [2:0] slot;
        logic [7:0] chamber;
        logic [7:0] subject;
        logic [6:0] nxt;
        logic       last;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        cmd_d;
    logic [2:0]  slot_d;
    logic [7:0]  chamber_d;
    logic [6:0]  subject_d;
    logic        incl_d;
    logic        o_valid;
    logic        o_found;
    logic [2:0]  o_result_slot;
    logic [7:0]  o_result_chamber;
    logic [7:0]  o_result_subject;
    logic [6:0]  o_next_subject;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // table mirror
    logic [7:0] tbl_chamber [NSLOT];
    logic [7:0] tbl_subject [NSLOT];
    logic [7:0] tbl_rank [NSLOT];
    logic [6:0] subj_counter;
    logic [2:0] auto_idx;

    t_answer pending_answers[$];
    int      errors;
    int      words_seen;
    int      idle_pct;

    save_slot_recency_table_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(cmd_d), .i_slot(slot_d), .i_chamber(chamber_d),
        .i_subject(subject_d), .i_include_auto(incl_d),
        .o_valid(o_valid), .o_found(o_found), .o_result_slot(o_result_slot),
        .o_result_chamber(o_result_chamber), .o_result_subject(o_result_subject),
        .o_next_subject(o_next_subject), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit is_free(int i);
        return tbl_chamber[i] == FREE_MARK;
    endfunction

    function automatic void push_answer(logic found, logic [2:0] s,
                                        logic [7:0] ch, logic [7:0] sj);
        t_answer a;
        a.found   = found;
        a.slot    = s;
        a.chamber = ch;
        a.subject = sj;
        a.nxt     = subj_counter;
        a.last    = 1'b0;
        pending_answers.push_back(a);
    endfunction

    function automatic void push_none();
        push_answer(1'b0, 3'd0, FREE_MARK, FREE_MARK);
    endfunction

    function automatic void push_slot(int s);
        push_answer(1'b1, s[2:0], tbl_chamber[s], tbl_subject[s]);
    endfunction

    // works out the result words of one accepted request
    function automatic void predict_request(t_cmd c, logic [2:0] s, logic [7:0] ch,
                                            logic [6:0] sj, logic incl);
        logic [7:0] prev;
        bit         got;
        int         best;
        bit         taken [NSLOT];
        t_answer    a;
        case (c)
            CMD_SAVE, CMD_CLEAR, CMD_INFO: begin
                prev = tbl_rank[s];
                if (c == CMD_SAVE && ch != FREE_MARK) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!is_free(i) && tbl_rank[i] < prev) tbl_rank[i]++;
                    tbl_chamber[s] = ch;
                    tbl_subject[s] = {1'b0, sj};
                    tbl_rank[s]    = 8'd0;
                end else if (c != CMD_INFO) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!is_free(i) && tbl_rank[i] > prev) tbl_rank[i]--;
                    tbl_chamber[s] = FREE_MARK;
                    tbl_subject[s] = FREE_MARK;
                    tbl_rank[s]    = FREE_MARK;
                end
                push_slot(s);
            end
            CMD_LATEST: begin
                got  = 0;
                best = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (is_free(i) || (i == auto_idx && !incl)) continue;
                    if (tbl_subject[i] == {1'b0, sj} &&
                        (!got || tbl_rank[i] < tbl_rank[best])) begin
                        got  = 1;
                        best = i;
                    end
                end
                if (got) push_slot(best);
                else push_none();
            end
            CMD_FREE: begin
                got = 0;
                for (int i = 0; i < NSLOT && !got; i++)
                    if (i != auto_idx && is_free(i)) begin
                        push_slot(i);
                        got = 1;
                    end
                if (!got) push_none();
            end
            CMD_NEXT: begin
                for (int n = 0; n < NSLOT + 1; n++) begin
                    got = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (!is_free(i) && tbl_subject[i] == {1'b0, subj_counter}) got = 1;
                    if (!got) break;
                    subj_counter = (subj_counter >= SUBJECT_MAX) ? 7'd0
                                                                 : subj_counter + 7'd1;
                end
                push_none();
            end
            CMD_LIST: begin
                for (int i = 0; i < NSLOT; i++)
                    taken[i] = is_free(i) || (i == auto_idx && !incl);
                got = 1;
                while (got) begin
                    got  = 0;
                    best = 0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (taken[i]) continue;
                        if (!got || tbl_rank[i] < tbl_rank[best]) begin
                            got  = 1;
                            best = i;
                        end
                    end
                    if (got) begin
                        taken[best] = 1;
                        push_slot(best);
                    end
                end
                if (pending_answers.size() == 0 ||
                    pending_answers[$].last == 1'b1) push_none();
            end
            default: push_none();
        endcase
        a = pending_answers.pop_back();
        a.last = 1'b1;
        pending_answers.push_back(a);
    endfunction

    // one request word on the start/busy handshake
    task automatic send_request(t_cmd c, logic [2:0] s, logic [7:0] ch,
                                logic [6:0] sj, logic incl);
        @(negedge i_clk);
        cmd_d     <= c;
        slot_d    <= s;
        chamber_d <= ch;
        subject_d <= sj;
        incl_d    <= incl;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_request(c, s, ch, sj, incl);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    // hold off until every pending word is back and the update pass is done
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (3 * NSLOT + 4) @(posedge i_clk);
    endtask

    task automatic write_autosave(logic [2:0] v);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {29'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        auto_idx = v;
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (pending_answers.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (o_found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_found); errors++;
                end
                if (o_result_slot !== e.slot) begin
                    $error("result_slot exp %0d got %0d", e.slot, o_result_slot); errors++;
                end
                if (o_result_chamber !== e.chamber) begin
                    $error("result_chamber exp %0d got %0d", e.chamber, o_result_chamber);
                    errors++;
                end
                if (o_result_subject !== e.subject) begin
                    $error("result_subject exp %0d got %0d", e.subject, o_result_subject);
                    errors++;
                end
                if (o_next_subject !== e.nxt) begin
                    $error("next_subject exp %0d got %0d", e.nxt, o_next_subject); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(CMD_INFO, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_INFO, 3'd7, 8'd0, 7'd0, 1'b1);
        send_request(CMD_LIST, 3'd0, 8'd0, 7'd0, 1'b1);
        send_request(CMD_LATEST, 3'd0, 8'd0, 7'd0, 1'b1);
        send_request(CMD_FREE, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_NEXT, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_UNKNOWN, 3'd5, 8'd12, 7'd3, 1'b1);
    endtask

    task automatic test_extremes();
        send_request(CMD_SAVE, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_SAVE, 3'd7, 8'd254, 7'd99, 1'b0);
        // the free marker as chamber frees the slot
        send_request(CMD_SAVE, 3'd7, 8'd255, 7'd5, 1'b0);
        send_request(CMD_SAVE, 3'd7, 8'd254, 7'd99, 1'b0);
        send_request(CMD_LIST, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_LIST, 3'd0, 8'd0, 7'd0, 1'b1);
        send_request(CMD_LATEST, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_LATEST, 3'd0, 8'd0, 7'd0, 1'b1);
        send_request(CMD_NEXT, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_CLEAR, 3'd3, 8'd0, 7'd0, 1'b0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++)
            send_request(CMD_SAVE, i[2:0], 8'(i * 30), 7'(i + 1), 1'b0);
        send_request(CMD_FREE, 3'd0, 8'd0, 7'd0, 1'b0);
        send_request(CMD_LIST, 3'd0, 8'd0, 7'd0, 1'b1);
        send_request(CMD_CLEAR, 3'd4, 8'd0, 7'd0, 1'b0);
        send_request(CMD_LIST, 3'd0, 8'd0, 7'd0, 1'b1);
    endtask

    // fill slots with the upcoming subjects so next subject jumps and wraps
    task automatic test_subject_wrap();
        logic [6:0] base;
        bit         wrapped;
        wrapped = 0;
        for (int r = 0; r < 40 && !wrapped; r++) begin
            base = subj_counter;
            for (int i = 0; i < NSLOT - 1; i++)
                send_request(CMD_SAVE, 3'(i + 1), 8'd7,
                             7'((base + i) % (SUBJECT_MAX + 1)), 1'b0);
            send_request(CMD_NEXT, 3'd0, 8'd0, 7'd0, 1'b0);
            wrapped = subj_counter < base;
        end
    endtask

    task automatic test_random_traffic(int count);
        int   r;
        t_cmd c;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) c = CMD_SAVE;
            else if (r < 50) c = CMD_CLEAR;
            else if (r < 60) c = CMD_LATEST;
            else if (r < 68) c = CMD_FREE;
            else if (r < 76) c = CMD_NEXT;
            else if (r < 88) c = CMD_LIST;
            else if (r < 97) c = CMD_INFO;
            else c = CMD_UNKNOWN;
            send_request(c, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         7'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                       : $urandom_range(0, 99)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        errors = 0;
        words_seen = 0;
        idle_pct = 0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_chamber[i] = FREE_MARK;
            tbl_subject[i] = FREE_MARK;
            tbl_rank[i]    = FREE_MARK;
        end
        subj_counter = 7'd0;
        auto_idx     = 3'd0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd_d     = CMD_SAVE;
        slot_d    = 3'd0;
        chamber_d = 8'd0;
        subject_d = 7'd0;
        incl_d    = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 3'd0;
        pwdata    = 32'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extremes();
        test_full_table();
        write_autosave(3'd7);
        test_subject_wrap();
        idle_pct = 55;
        test_random_traffic(8);
        write_autosave(3'd3);
        idle_pct = 11;
        test_random_traffic(8);
        write_autosave(3'd0);
        idle_pct = 0;
        test_random_traffic(8);
        drain();

        $display("covered all commands, empty/full tables, subject wrap, autosave at 0, 7 and 3");
        $display("%0d result words checked under several sender idle levels", words_seen);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/ssrt_pkg.sv
rtl/core/ssrt_cell.sv
rtl/core/save_slot_recency_table_unit.sv
rtl/core/ssrt_checker.sv
test/tb_save_slot_recency_table_unit.sv
